### hdl/hang_agc_gain_controller_top_assert.svh
// assertion macros for the hang agc gain controller
`ifndef HANG_AGC_GAIN_CONTROLLER_TOP_ASSERT_SVH
`define HANG_AGC_GAIN_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HAGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HAGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/hagc_pkg.sv
// types, codes and constants of the hang agc gain controller
`timescale 1ns / 1ps
`default_nettype none

package hagc_pkg;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SLOW     = 3'd1,
		OP_FAST     = 3'd2,
		OP_MANUAL   = 3'd3,
		OP_SET_SLOW = 3'd4,
		OP_SET_FAST = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_SET_POINT = 2'd0,
		REG_ATTACK    = 2'd1,
		REG_RECOVERY  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [11:0] adc_sample;
		logic [4:0]  argument;
	} in_item_t;

	typedef struct packed {
		logic [11:0] dac_level;
		logic        dac_write;
		logic [7:0]  meter_reading;
		logic        manual_active;
	} out_item_t;

	localparam int CFG_DATA_W = 12;

	localparam logic [11:0] LEVEL_MIN = 12'd1600;
	localparam logic [11:0] LEVEL_MAX = 12'd3200;

	localparam logic signed [12:0] ERR_RISE  = 13'sd2;
	localparam logic signed [12:0] ERR_LARGE = -13'sd100;
	localparam logic signed [12:0] ERR_SMALL = -13'sd20;

	localparam logic [11:0] RESET_SET_POINT = 12'd1800;
	localparam logic [7:0]  RESET_ATTACK    = 8'd10;
	localparam logic [7:0]  RESET_RECOVERY  = 8'd1;
	localparam logic [10:0] RESET_HANG      = 11'd2000;
	localparam logic [6:0]  RESET_FAST_HANG = 7'd100;

	localparam int MANUAL_STEPS = 19;
	localparam logic [4:0] MANUAL_LAST = 5'(MANUAL_STEPS - 1);

	localparam logic [11:0] MANUAL_LEVELS [32] = '{
		12'd1958, 12'd1972, 12'd1988, 12'd2010, 12'd2056, 12'd2115, 12'd2172, 12'd2229,
		12'd2286, 12'd2344, 12'd2413, 12'd2489, 12'd2566, 12'd2649, 12'd2742, 12'd2837,
		12'd2937, 12'd3047, 12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166,
		12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166, 12'd3166
	};

	// manual level lookup, index saturates at the last step
	function automatic logic [11:0] manual_level(input logic [4:0] arg);
		logic [4:0] idx;
		idx = (arg > MANUAL_LAST) ? MANUAL_LAST : arg;
		return MANUAL_LEVELS[idx];
	endfunction

endpackage

`default_nettype wire

### hdl/hagc_ifs.sv
// request and result channels of the hang agc gain controller
`timescale 1ns / 1ps
`default_nettype none

interface hagc_in_if;
	import hagc_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hagc_out_if;
	import hagc_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/hang_agc_gain_controller_top.sv
// hang agc gain controller: request and result channels, three config registers
//
// item carries one request per accepted transfer: a detector tick or a command
// (slow/fast hang select, manual level, set slow/fast hang time). result carries
// exactly one item per request: dac level, write flag, meter byte, manual flag.
// both channels use valid/ready; a transfer happens when both are high.
// the loop state updates at the edge a request is accepted, and the result is
// written at that edge into the output register, or into the skid register.
// one request per cycle is taken while the skid register is empty; the single
// add, compare and clamp chain on the level register feeds the result regs.
// a two-entry output stage (result register plus skid register) lets a request
// be taken while an earlier result still waits; ready drops only with both full.
// config registers are written with cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, the block does not enforce it. unknown indexes are ignored.
// arst_n clears all loop state to its start values (level 1600, hold 0,
// hang 2000, fast hang 100, auto mode, meter 0) and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

`include "hang_agc_gain_controller_top_assert.svh"

module hang_agc_gain_controller_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	hagc_in_if.sink                              item,
	hagc_out_if.source                           result,
	input  wire logic                            cfg_write,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [hagc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hagc_pkg::*;

	logic [11:0] set_point_q;
	logic [7:0]  attack_q;
	logic [7:0]  recovery_q;

	logic [11:0] level_q, level_d;
	logic [10:0] hold_q, hold_d;
	logic [10:0] hang_q, hang_d;
	logic [10:0] slow_q, slow_d;
	logic [6:0]  fast_q, fast_d;
	logic        manual_q, manual_d;
	logic [7:0]  meter_q, meter_d;
	logic        wrote;

	logic             out_valid_q;
	out_item_t        out_data_q;
	logic             skid_valid_q;
	out_item_t        skid_data_q;
	out_item_t        new_result;
	logic             accept;
	logic             drain;

	op_t               op;
	logic signed [12:0] err;
	logic [12:0]        rise_sum;
	logic [10:0]        attack6;
	logic [11:0]        meter_diff;

	// level minus amount, floored at the minimum level
	function automatic logic [11:0] floor_sub(input logic [11:0] lvl, input logic [10:0] amt);
		logic [12:0] diff;
		diff = {1'b0, lvl} - {2'b00, amt};
		if (diff[12] || (diff[11:0] < LEVEL_MIN)) begin
			return LEVEL_MIN;
		end
		return diff[11:0];
	endfunction

	assign item.ready = !skid_valid_q;
	assign accept     = item.valid && item.ready;
	assign drain      = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assign op       = op_t'(item.data.operation);
	assign err      = $signed({1'b0, set_point_q}) - $signed({1'b0, item.data.adc_sample});
	assign rise_sum = {1'b0, level_q} + {5'b00000, recovery_q};
	assign attack6  = {1'b0, attack_q, 2'b00} + {2'b00, attack_q, 1'b0};

	always_comb begin
		level_d    = level_q;
		hold_d     = hold_q;
		hang_d     = hang_q;
		slow_d     = slow_q;
		fast_d     = fast_q;
		manual_d   = manual_q;
		meter_d    = meter_q;
		wrote      = 1'b0;
		meter_diff = 12'd0;
		unique case (op)
			OP_TICK: begin
				if (!manual_q) begin
					if (hold_q == 11'd0) begin
						if (err > ERR_RISE) begin
							level_d = (rise_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : rise_sum[11:0];
							wrote   = 1'b1;
						end
					end else begin
						hold_d = hold_q - 11'd1;
					end
					// a large error applies the big fall and then the small one
					if (err < ERR_LARGE) begin
						level_d = floor_sub(level_d, attack6);
						hold_d  = hang_q;
						wrote   = 1'b1;
					end
					if (err < ERR_SMALL) begin
						level_d = floor_sub(level_d, {3'b000, attack_q});
						hold_d  = hang_q;
						wrote   = 1'b1;
					end
					meter_diff = level_d - LEVEL_MIN;
					meter_d    = meter_diff[10:3];
				end
			end
			OP_SLOW: begin
				manual_d = 1'b0;
				hang_d   = slow_q;
			end
			OP_FAST: begin
				manual_d = 1'b0;
				hang_d   = {4'b0000, fast_q};
			end
			OP_MANUAL: begin
				manual_d = 1'b1;
				level_d  = manual_level(item.data.argument);
				wrote    = 1'b1;
			end
			OP_SET_SLOW: begin
				slow_d = {6'b000000, item.data.argument};
			end
			OP_SET_FAST: begin
				fast_d = {2'b00, item.data.argument};
			end
			default: begin
			end
		endcase
	end

	assign new_result = '{
		dac_level:     level_d,
		dac_write:     wrote,
		meter_reading: meter_d,
		manual_active: manual_d
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_point_q <= RESET_SET_POINT;
			attack_q    <= RESET_ATTACK;
			recovery_q  <= RESET_RECOVERY;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_SET_POINT: set_point_q <= cfg_data[11:0];
				REG_ATTACK:    attack_q    <= cfg_data[7:0];
				REG_RECOVERY:  recovery_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= LEVEL_MIN;
			hold_q   <= 11'd0;
			hang_q   <= RESET_HANG;
			slow_q   <= RESET_HANG;
			fast_q   <= RESET_FAST_HANG;
			manual_q <= 1'b0;
			meter_q  <= 8'd0;
		end else if (accept) begin
			level_q  <= level_d;
			hold_q   <= hold_d;
			hang_q   <= hang_d;
			slow_q   <= slow_d;
			fast_q   <= fast_d;
			manual_q <= manual_d;
			meter_q  <= meter_d;
		end
	end

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= new_result;
			end
		end else if (accept) begin
			skid_data_q <= new_result;
		end
	end

	`HAGC_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q,
		"skid entry held while output register empty")
	`HAGC_ASSERT_NOW(a_level_range, clk, arst_n, 1'b1,
		(level_q >= LEVEL_MIN) && (level_q <= LEVEL_MAX), "gain level out of range")
	`HAGC_ASSERT_NEXT(a_manual_tick_hold, clk, arst_n, accept && (op == OP_TICK) && manual_q,
		$stable(level_q) && $stable(meter_q) && $stable(hold_q),
		"tick in manual mode changed loop state")

endmodule

`default_nettype wire
